@@ sv/bmq_pkg.sv @@
// bmq_pkg: shared types and codes for the blocking message queue
// holds command, status and wait codes, the channel payload structs
// and the request record passed from the front end to the executor
package bmq_pkg;

    // command codes of an input transaction
    typedef enum logic [1:0] {
        CMD_POST   = 2'd0,
        CMD_PEND   = 2'd1,
        CMD_STATUS = 2'd2,
        CMD_FLUSH  = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BLOCKED  = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_TOO_LONG = 3'd4
    } t_status;

    // per-task wait kind
    typedef enum logic [1:0] {
        WAIT_NONE  = 2'd0,
        WAIT_SPACE = 2'd1,
        WAIT_DATA  = 2'd2
    } t_wait;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MSG_CAPACITY  = 1'b0,
        CFG_MAX_MSG_BYTES = 1'b1
    } t_cfg_idx;

    localparam int CFG_DATA_W = 5;
    localparam int PAYLOAD_W  = 64;
    localparam int WAKE_W     = 8;

    // input transaction
    typedef struct packed {
        logic [1:0]           command;
        logic [2:0]           task_id;
        logic                 may_block;
        logic [3:0]           in_length;
        logic [PAYLOAD_W-1:0] in_payload;
    } t_bmq_in;

    // result transaction
    typedef struct packed {
        t_status              status;
        logic [3:0]           out_length;
        logic [PAYLOAD_W-1:0] out_payload;
        logic [4:0]           free_slots;
        logic [WAKE_W-1:0]    wake_mask;
    } t_bmq_out;

    // classified request between front end and executor
    typedef struct packed {
        t_cmd                 cmd;
        logic [2:0]           task_id;
        logic                 may_block;
        logic                 too_long;
        logic [3:0]           length;
        logic [PAYLOAD_W-1:0] payload;
    } t_req;

endpackage

@@ sv/bmq_front.sv @@
// bmq_front: accepts input transactions and classifies them
// decodes the command, checks the length limit and clears unused bytes
// depends on bmq_pkg
module bmq_front import bmq_pkg::*; #(
    parameter int MSG_BYTES = 8
) (
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_bmq_in    i_in_data,
    input  logic [3:0] i_cfg_max_bytes,
    output logic       o_req_valid,
    input  logic       i_req_ready,
    output t_req       o_req
);

    logic [3:0]           w_limit;
    logic [PAYLOAD_W-1:0] w_masked;

    // handshake passes straight to the request queue
    assign o_req_valid = i_in_valid;
    assign o_in_ready  = i_req_ready;

    // effective length limit is the smaller of register and storage width
    always_comb begin
        if (i_cfg_max_bytes > 4'(MSG_BYTES)) begin
            w_limit = 4'(MSG_BYTES);
        end else begin
            w_limit = i_cfg_max_bytes;
        end
    end

    // drop bytes at or beyond the message length
    always_comb begin
        for (int b = 0; b < PAYLOAD_W / 8; b++) begin
            w_masked[b*8 +: 8] = (4'(b) < i_in_data.in_length) ?
                                 i_in_data.in_payload[b*8 +: 8] : 8'h00;
        end
    end

    // request record
    always_comb begin
        o_req.cmd       = t_cmd'(i_in_data.command);
        o_req.task_id   = i_in_data.task_id;
        o_req.may_block = i_in_data.may_block;
        o_req.too_long  = i_in_data.in_length > w_limit;
        o_req.length    = i_in_data.in_length;
        o_req.payload   = w_masked;
    end

endmodule

@@ sv/bmq_fifo.sv @@
// bmq_fifo: two-entry request queue between front end and executor
// lets either side stall on its own at full rate
// depends on bmq_pkg
module bmq_fifo import bmq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_req i_wr_data,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_req o_rd_data
);

    t_req       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_wr_ready = r_count != 2'd2;
    assign o_rd_valid = r_count != 2'd0;
    assign o_rd_data  = r_entry[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

@@ sv/bmq_back.sv @@
// bmq_back: executes requests on the message ring and the waiter table
// holds the ring memory, pointers, used count and the result register
// depends on bmq_pkg
module bmq_back import bmq_pkg::*; #(
    parameter int SLOT_COUNT = 16,
    parameter int TASK_COUNT = 8,
    parameter int MSG_BYTES  = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [4:0] i_cfg_capacity,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_req       i_req,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_bmq_out   o_out_data
);

    localparam int PTR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int DW    = MSG_BYTES * 8;
    localparam int HW    = (TASK_COUNT > WAKE_W) ? TASK_COUNT : WAKE_W;

    // ring memory
    logic [DW-1:0]    mem_payload [SLOT_COUNT];
    logic [3:0]       mem_length  [SLOT_COUNT];

    // ring control and waiter table
    logic [PTR_W-1:0] r_rd_slot, n_rd_slot;
    logic [PTR_W-1:0] r_wr_slot, n_wr_slot;
    logic [CNT_W-1:0] r_used, n_used;
    t_wait            r_wait [TASK_COUNT];
    t_wait            n_wait [TASK_COUNT];

    // result register
    logic             r_out_valid;
    t_status          r_status;
    logic [4:0]       r_free;
    logic [WAKE_W-1:0] r_wake;
    logic             r_take;
    logic [DW-1:0]    r_rd_payload;
    logic [3:0]       r_rd_length;

    logic             w_exec;
    logic [CNT_W-1:0] w_cap;
    logic             w_full;
    logic             w_empty;
    logic             w_push;
    logic             w_take;
    t_status          w_status;
    logic [4:0]       w_free;
    logic             w_rel_en;
    t_wait            w_rel_kind;
    logic             w_blk_en;
    t_wait            w_blk_kind;
    logic [HW-1:0]    w_hit;

    // slot pointer advance, wrapping at the capacity
    function automatic logic [PTR_W-1:0] f_advance(input logic [PTR_W-1:0] p,
                                                   input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] v_next;
        v_next = CNT_W'(p) + CNT_W'(1);
        return (v_next >= c) ? '0 : PTR_W'(v_next);
    endfunction

    assign o_req_ready = !r_out_valid || i_out_ready;
    assign w_exec      = i_req_valid && o_req_ready;

    // capacity clamped to one .. SLOT_COUNT
    always_comb begin
        if (i_cfg_capacity == 5'd0) begin
            w_cap = CNT_W'(1);
        end else if (32'(i_cfg_capacity) > SLOT_COUNT) begin
            w_cap = CNT_W'(SLOT_COUNT);
        end else begin
            w_cap = CNT_W'(i_cfg_capacity);
        end
    end

    assign w_full  = r_used >= w_cap;
    assign w_empty = r_used == '0;

    // command execution
    always_comb begin
        n_rd_slot  = r_rd_slot;
        n_wr_slot  = r_wr_slot;
        n_used     = r_used;
        w_push     = 1'b0;
        w_take     = 1'b0;
        w_status   = ST_OK;
        w_free     = 5'd0;
        w_rel_en   = 1'b0;
        w_rel_kind = WAIT_NONE;
        w_blk_en   = 1'b0;
        w_blk_kind = WAIT_NONE;
        unique case (i_req.cmd)
            CMD_POST: begin
                if (i_req.too_long) begin
                    w_status = ST_TOO_LONG;
                end else if (w_full) begin
                    if (i_req.may_block) begin
                        w_blk_en   = 1'b1;
                        w_blk_kind = WAIT_SPACE;
                        w_status   = ST_BLOCKED;
                    end else begin
                        w_status = ST_FULL;
                    end
                end else begin
                    w_push     = 1'b1;
                    n_wr_slot  = f_advance(r_wr_slot, w_cap);
                    n_used     = r_used + CNT_W'(1);
                    w_rel_en   = 1'b1;
                    w_rel_kind = WAIT_DATA;
                end
            end
            CMD_PEND: begin
                if (w_empty) begin
                    if (i_req.may_block) begin
                        w_blk_en   = 1'b1;
                        w_blk_kind = WAIT_DATA;
                        w_status   = ST_BLOCKED;
                    end else begin
                        w_status = ST_EMPTY;
                    end
                end else begin
                    w_take     = 1'b1;
                    n_rd_slot  = f_advance(r_rd_slot, w_cap);
                    n_used     = r_used - CNT_W'(1);
                    w_rel_en   = 1'b1;
                    w_rel_kind = WAIT_SPACE;
                end
            end
            CMD_STATUS: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_free = 5'(w_cap - r_used);
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end
                end
            end
            CMD_FLUSH: begin
                n_rd_slot  = '0;
                n_wr_slot  = '0;
                n_used     = '0;
                w_rel_en   = 1'b1;
                w_rel_kind = WAIT_NONE;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // waiter table: release matching waiters, then record a new waiter
    always_comb begin
        w_hit = '0;
        for (int i = 0; i < TASK_COUNT; i++) begin
            n_wait[i] = r_wait[i];
            if (w_rel_en) begin
                if (w_rel_kind == WAIT_NONE) begin
                    w_hit[i] = r_wait[i] != WAIT_NONE;
                end else begin
                    w_hit[i] = r_wait[i] == w_rel_kind;
                end
            end
            if (w_hit[i]) begin
                n_wait[i] = WAIT_NONE;
            end
            if (w_blk_en && (i == int'(i_req.task_id))) begin
                n_wait[i] = w_blk_kind;
            end
        end
    end

    // ring write and registered ring read
    always_ff @(posedge i_clk) begin
        if (w_exec && w_push) begin
            mem_payload[r_wr_slot] <= DW'(i_req.payload);
            mem_length[r_wr_slot]  <= i_req.length;
        end
        if (w_exec && w_take) begin
            r_rd_payload <= mem_payload[r_rd_slot];
            r_rd_length  <= mem_length[r_rd_slot];
        end
    end

    // ring control and waiter table registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_slot <= '0;
            r_wr_slot <= '0;
            r_used    <= '0;
            for (int i = 0; i < TASK_COUNT; i++) begin
                r_wait[i] <= WAIT_NONE;
            end
        end else if (w_exec) begin
            r_rd_slot <= n_rd_slot;
            r_wr_slot <= n_wr_slot;
            r_used    <= n_used;
            for (int i = 0; i < TASK_COUNT; i++) begin
                r_wait[i] <= n_wait[i];
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register fields
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_status <= w_status;
            r_free   <= w_free;
            r_wake   <= w_hit[WAKE_W-1:0];
            r_take   <= w_take;
        end
    end

    // result transaction
    assign o_out_valid            = r_out_valid;
    assign o_out_data.status      = r_status;
    assign o_out_data.out_length  = r_take ? r_rd_length : 4'd0;
    assign o_out_data.out_payload = r_take ? PAYLOAD_W'(r_rd_payload) : '0;
    assign o_out_data.free_slots  = r_free;
    assign o_out_data.wake_mask   = r_wake;

endmodule

@@ sv/blocking_message_queue.sv @@
// Path: an accepted transaction is registered in the request queue, then executed into the result register.
// Throughput: one transaction per cycle sustained while the result output is not stalled,
// executed in the executor stage behind the two-entry request queue.
// Reset (synchronous, active low): pointers, used count and waiter table cleared,
// capacity 16 and length limit 8; ring contents stay undefined, no clearing pass.
// depends on bmq_pkg, bmq_front, bmq_fifo, bmq_back
module blocking_message_queue import bmq_pkg::*; #(
    parameter int SLOT_COUNT = 16,
    parameter int TASK_COUNT = 8,
    parameter int MSG_BYTES  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_bmq_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_bmq_out              o_out_data,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [4:0] r_cfg_capacity;
    logic [3:0] r_cfg_max_bytes;
    logic       w_fe_valid;
    logic       w_fe_ready;
    t_req       w_fe_req;
    logic       w_be_valid;
    logic       w_be_ready;
    t_req       w_be_req;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_capacity  <= 5'd16;
            r_cfg_max_bytes <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MSG_CAPACITY:  r_cfg_capacity  <= i_cfg_wdata[4:0];
                CFG_MAX_MSG_BYTES: r_cfg_max_bytes <= i_cfg_wdata[3:0];
                default:           r_cfg_capacity  <= r_cfg_capacity;
            endcase
        end
    end

    // front end
    bmq_front #(
        .MSG_BYTES (MSG_BYTES)
    ) u_front (
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_data       (i_in_data),
        .i_cfg_max_bytes (r_cfg_max_bytes),
        .o_req_valid     (w_fe_valid),
        .i_req_ready     (w_fe_ready),
        .o_req           (w_fe_req)
    );

    // request queue
    bmq_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fe_valid),
        .o_wr_ready (w_fe_ready),
        .i_wr_data  (w_fe_req),
        .o_rd_valid (w_be_valid),
        .i_rd_ready (w_be_ready),
        .o_rd_data  (w_be_req)
    );

    // executor
    bmq_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .TASK_COUNT (TASK_COUNT),
        .MSG_BYTES  (MSG_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_capacity (r_cfg_capacity),
        .i_req_valid    (w_be_valid),
        .o_req_ready    (w_be_ready),
        .i_req          (w_be_req),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_data     (o_out_data)
    );

endmodule

@@ sv/bmq_checker.sv @@
// bmq_checker: port-level checks of the blocking message queue results
// bound to blocking_message_queue; depends on bmq_pkg
module bmq_checker import bmq_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_bmq_out o_out_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // a failed or blocked request carries no message and wakes no task
    a_fail_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |->
        (o_out_data.out_length == 4'd0) && (o_out_data.wake_mask == '0))
        else $error("non-ok result carries data or wakeups");

    // no payload bytes without a length
    a_len_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.out_length == 4'd0) |->
        o_out_data.out_payload == '0)
        else $error("payload without length");

    // free slots reported only when the ring is not full
    a_free_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.free_slots != 5'd0) |->
        (o_out_data.status == ST_OK || o_out_data.status == ST_EMPTY))
        else $error("free slots with full status");

endmodule

bind blocking_message_queue bmq_checker u_bmq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
